FILE: src/bmpw_pkg.sv
package bmpw_pkg;

	localparam int unsigned DIM_W      = 13;
	localparam int unsigned DIM_MAX    = 8191;
	localparam int unsigned IMG_W      = 28;
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = 2;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd320;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd240;

	localparam logic [7:0]  SIG_B       = 8'h42;
	localparam logic [7:0]  SIG_M       = 8'h4D;
	localparam logic [7:0]  HDR_BYTES   = 8'd54;
	localparam logic [7:0]  INFO_BYTES  = 8'd40;
	localparam logic [7:0]  BITS_PER_PX = 8'd24;
	localparam logic [7:0]  PLANES      = 8'd1;
	localparam logic [IDX_W-1:0] HDR_LAST = 6'd53;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_PIXEL = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		CMD_HEADER = 2'd0,
		CMD_PIXEL  = 2'd1,
		CMD_DROP   = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		action_t     action;
		logic [15:0] pixel_rgb565;
	} req_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_run;
		logic       frame_done;
		logic       status;
	} rsp_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [15:0]       pixel;
		logic [1:0]        pad;
		logic              frame_end;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
		logic [IMG_W-1:0]  image_size;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

FILE: src/bmpw_fifo.sv
module bmpw_fifo
	import bmpw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       wdata,
	input  logic       pop,
	output cmd_t       rdata,
	output fifo_stat_t stat
);

	cmd_t                 entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;

	assign stat.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/bmpw_front.sv
module bmpw_front
	import bmpw_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             req_valid,
	input  req_t             req,
	output logic             req_stall,
	input  fifo_stat_t       fifo_stat,
	output logic             push,
	output cmd_t             push_cmd
);

	localparam int unsigned WidthCap  = (MAX_WIDTH > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
	localparam int unsigned HeightCap = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;

	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;
	logic [DIM_W-1:0] cur_width_q;
	logic [DIM_W-1:0] cur_height_q;
	logic [DIM_W-1:0] column_q;
	logic [DIM_W-1:0] row_q;
	logic             active_q;

	logic [DIM_W-1:0] start_width;
	logic [DIM_W-1:0] start_height;
	logic [14:0]      row_stride;
	logic [IMG_W-1:0] image_size;
	logic [DIM_W-1:0] column_next;
	logic [DIM_W-1:0] row_next;
	logic             row_end;
	logic             frame_end;
	logic             accept;

	assign req_stall = fifo_stat.full;
	assign accept    = req_valid && !fifo_stat.full;
	assign push      = accept;

	// Out-of-range sizes are saturated when a frame starts.
	always_comb begin
		if (frame_width_q == '0) begin
			start_width = 13'd1;
		end else if (frame_width_q > DIM_W'(WidthCap)) begin
			start_width = DIM_W'(WidthCap);
		end else begin
			start_width = frame_width_q;
		end
		if (frame_height_q == '0) begin
			start_height = 13'd1;
		end else if (frame_height_q > DIM_W'(HeightCap)) begin
			start_height = DIM_W'(HeightCap);
		end else begin
			start_height = frame_height_q;
		end
	end

	assign row_stride = ({2'b00, start_width} + {1'b0, start_width, 1'b0} + 15'd3) & ~15'd3;
	assign image_size = {13'b0, row_stride} * {15'b0, start_height};

	assign column_next = column_q + 1'b1;
	assign row_next    = row_q + 1'b1;
	assign row_end     = (column_next >= cur_width_q);
	assign frame_end   = row_end && (row_next >= cur_height_q);

	always_comb begin
		push_cmd            = '0;
		push_cmd.pixel      = req.pixel_rgb565;
		push_cmd.width      = start_width;
		push_cmd.height     = start_height;
		push_cmd.image_size = image_size;
		if (req.action == ACT_START) begin
			push_cmd.kind = CMD_HEADER;
		end else if (!active_q) begin
			push_cmd.kind = CMD_DROP;
		end else begin
			push_cmd.kind      = CMD_PIXEL;
			push_cmd.pad       = row_end ? cur_width_q[1:0] : 2'd0;
			push_cmd.frame_end = frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_WIDTH:  frame_width_q  <= cfg_data;
				REG_HEIGHT: frame_height_q <= cfg_data;
				default:    frame_width_q  <= frame_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_width_q  <= WIDTH_RESET;
			cur_height_q <= HEIGHT_RESET;
			column_q     <= '0;
			row_q        <= '0;
			active_q     <= 1'b0;
		end else if (accept) begin
			if (req.action == ACT_START) begin
				cur_width_q  <= start_width;
				cur_height_q <= start_height;
				column_q     <= '0;
				row_q        <= '0;
				active_q     <= 1'b1;
			end else if (active_q) begin
				if (row_end) begin
					column_q <= '0;
					row_q    <= frame_end ? '0 : row_next;
					active_q <= !frame_end;
				end else begin
					column_q <= column_next;
				end
			end
		end
	end

endmodule

FILE: src/bmpw_back.sv
module bmpw_back
	import bmpw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  fifo_stat_t fifo_stat,
	output logic       pop,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp
);

	logic [IDX_W-1:0] idx_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [IDX_W-1:0] last_idx;
	logic             is_last;
	logic             advance;
	logic [31:0]      total_len;
	logic [1:0]       lane;
	logic [7:0]       hdr_byte;
	logic [7:0]       px_byte;
	rsp_t             next_rsp;

	function automatic logic [7:0] pick_byte(input logic [31:0] word, input logic [1:0] sel);
		pick_byte = word[{sel, 3'b000} +: 8];
	endfunction

	assign advance   = !fifo_stat.empty && (!rsp_valid_q || !rsp_stall);
	assign total_len = {4'b0, head.image_size} + {24'b0, HDR_BYTES};
	// Every multi-byte field of interest starts two bytes past a 4-byte boundary.
	assign lane      = idx_q[1:0] - 2'd2;

	always_comb begin
		unique case (head.kind)
			CMD_HEADER: last_idx = HDR_LAST;
			CMD_PIXEL:  last_idx = 6'd2 + {4'b0, head.pad};
			CMD_DROP:   last_idx = '0;
			default:    last_idx = '0;
		endcase
	end

	assign is_last = (idx_q == last_idx);
	assign pop     = advance && is_last;

	always_comb begin
		case (idx_q) inside
			6'd0:          hdr_byte = SIG_B;
			6'd1:          hdr_byte = SIG_M;
			[6'd2:6'd5]:   hdr_byte = pick_byte(total_len, lane);
			6'd10:         hdr_byte = HDR_BYTES;
			6'd14:         hdr_byte = INFO_BYTES;
			[6'd18:6'd21]: hdr_byte = pick_byte({19'b0, head.width}, lane);
			[6'd22:6'd25]: hdr_byte = pick_byte({19'b0, head.height}, lane);
			6'd26:         hdr_byte = PLANES;
			6'd28:         hdr_byte = BITS_PER_PX;
			[6'd34:6'd37]: hdr_byte = pick_byte({4'b0, head.image_size}, lane);
			default:       hdr_byte = 8'h00;
		endcase
	end

	// Components widen to 8 bits by repeating their top bits; padding bytes are zero.
	always_comb begin
		case (idx_q)
			6'd0:    px_byte = {head.pixel[4:0], head.pixel[4:2]};
			6'd1:    px_byte = {head.pixel[10:5], head.pixel[10:9]};
			6'd2:    px_byte = {head.pixel[15:11], head.pixel[15:13]};
			default: px_byte = 8'h00;
		endcase
	end

	always_comb begin
		next_rsp             = '0;
		next_rsp.last_of_run = is_last;
		unique case (head.kind)
			CMD_HEADER: next_rsp.data_byte = hdr_byte;
			CMD_PIXEL: begin
				next_rsp.data_byte  = px_byte;
				next_rsp.frame_done = is_last && head.frame_end;
			end
			CMD_DROP:   next_rsp.status = 1'b1;
			default:    next_rsp.status = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= next_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= is_last ? '0 : idx_q + 1'b1;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: src/bmp_rgb565_stream_writer.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_t: action, pixel_rgb565
// rsp      out        rsp_valid/rsp_stall   rsp_t: data_byte, last_of_run, frame_done, status
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data (frame_width, frame_height)
//
// The output emits one byte per cycle from the head of a four-entry command queue while
// it is not empty and rsp_stall is low. A pixel request gives 3 bytes, 3 + (width mod 4)
// at the end of a row, a start request 54 bytes and a dropped pixel 1 byte.
// Requests are taken at one per cycle until the queue fills, then req_stall rises.
// The output register holds its byte while rsp_stall is high.
// Reset clears the queue, counters and frame state and loads sizes 320 by 240.
module bmp_rgb565_stream_writer
	import bmpw_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             req_valid,
	output logic             req_stall,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output rsp_t             rsp
);

	fifo_stat_t fifo_stat;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head;

	assign cfg_ready = 1'b1;

	bmpw_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	bmpw_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (head),
		.stat   (fifo_stat)
	);

	bmpw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: src/bmpw_checker.sv
module bmpw_checker
	import bmpw_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic             cfg_index,
	input logic [DIM_W-1:0] cfg_data,
	input logic             req_valid,
	input logic             req_stall,
	input req_t             req,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input rsp_t             rsp
);

	// A dropped pixel is a single zero byte that ends its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.last_of_run && !rsp.frame_done && rsp.data_byte == 8'h00)
		else $error("dropped pixel response malformed");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.frame_done |-> rsp.last_of_run && !rsp.status)
		else $error("frame_done away from the end of a request");

	// The byte after a frame's last byte must not carry frame_done.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && rsp.frame_done ##1 rsp_valid |-> !rsp.frame_done)
		else $error("frame_done repeated on consecutive bytes");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind bmp_rgb565_stream_writer bmpw_checker u_checker (.*);

FILE: tb/bmpw_byte_checker.sv
`timescale 1ns / 1ps

module bmpw_byte_checker
	import bmpw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             req_valid,
	input  logic             req_stall,
	input  req_t             req,
	input  logic             rsp_valid,
	input  logic             rsp_stall,
	input  rsp_t             rsp,
	output int unsigned      pending,
	output int unsigned      errors
);

	localparam int unsigned WIDTH_CAP  = 4096;
	localparam int unsigned HEIGHT_CAP = 4096;

	rsp_t        byte_q[$];
	rsp_t        run_buf [0:53];
	int unsigned run_len;

	logic [DIM_W-1:0] width_reg  = WIDTH_RESET;
	logic [DIM_W-1:0] height_reg = HEIGHT_RESET;
	int unsigned      frame_w    = 320;
	int unsigned      frame_h    = 240;
	int unsigned      col_cnt    = 0;
	int unsigned      row_cnt    = 0;
	logic             in_frame   = 1'b0;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned cap);
		if (v == '0)
			return 1;
		if (v > cap)
			return cap;
		return 32'(v);
	endfunction

	function automatic rsp_t plain_byte(input logic [7:0] d);
		rsp_t r;
		r = '0;
		r.data_byte = d;
		return r;
	endfunction

	task automatic put_byte(input logic [7:0] d);
		run_buf[run_len] = plain_byte(d);
		run_len++;
	endtask

	task automatic put_word(input logic [31:0] v);
		int i;
		for (i = 0; i < 4; i++)
			put_byte(v[8*i +: 8]);
	endtask

	task automatic build_header();
		logic [31:0] stride_bytes;
		logic [31:0] image_size;
		stride_bytes = (frame_w * 3 + 3) & ~32'd3;
		image_size   = stride_bytes * frame_h;
		put_byte(SIG_B);
		put_byte(SIG_M);
		put_word(32'(HDR_BYTES) + image_size);
		// Both reserved halfwords are zero.
		put_word(32'd0);
		put_word(32'(HDR_BYTES));
		put_word(32'(INFO_BYTES));
		put_word(frame_w);
		put_word(frame_h);
		put_byte(PLANES);
		put_byte(8'd0);
		put_byte(BITS_PER_PX);
		put_byte(8'd0);
		put_word(32'd0);
		put_word(image_size);
		repeat (4) put_word(32'd0);
	endtask

	task automatic predict_request(input req_t r);
		logic [4:0] r5;
		logic [5:0] g6;
		logic [4:0] b5;
		int         i;
		run_len = 0;
		if (r.action == ACT_START) begin
			frame_w  = clamp_dim(width_reg, WIDTH_CAP);
			frame_h  = clamp_dim(height_reg, HEIGHT_CAP);
			col_cnt  = 0;
			row_cnt  = 0;
			in_frame = 1'b1;
			build_header();
		end else if (!in_frame) begin
			put_byte(8'd0);
			run_buf[0].status = 1'b1;
		end else begin
			{r5, g6, b5} = r.pixel_rgb565;
			put_byte({b5, b5[4:2]});
			put_byte({g6, g6[5:4]});
			put_byte({r5, r5[4:2]});
			col_cnt++;
			if (col_cnt >= frame_w) begin
				// Rows are padded with zeros to a multiple of four bytes.
				for (i = 0; i < (frame_w % 4); i++)
					put_byte(8'd0);
				col_cnt = 0;
				row_cnt++;
				if (row_cnt >= frame_h) begin
					run_buf[run_len-1].frame_done = 1'b1;
					in_frame = 1'b0;
					row_cnt  = 0;
				end
			end
		end
		run_buf[run_len-1].last_of_run = 1'b1;
		for (i = 0; i < run_len; i++)
			byte_q.push_back(run_buf[i]);
	endtask

	task automatic match_result(input rsp_t got);
		rsp_t want;
		if (byte_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: unexpected output byte %02h last %b done %b status %b", $time,
					got.data_byte, got.last_of_run, got.frame_done, got.status);
		end else begin
			want = byte_q.pop_front();
			if (got.data_byte !== want.data_byte || got.last_of_run !== want.last_of_run ||
			    got.frame_done !== want.frame_done || got.status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display("%0t: output mismatch: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
						$time, want.data_byte, want.last_of_run, want.frame_done, want.status,
						got.data_byte, got.last_of_run, got.frame_done, got.status);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			frame_w    = 320;
			frame_h    = 240;
			col_cnt    = 0;
			row_cnt    = 0;
			in_frame   = 1'b0;
			byte_q.delete();
			pending    = 0;
			errors     = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
			end
			if (rsp_valid && !rsp_stall)
				match_result(rsp);
			if (req_valid && !req_stall)
				predict_request(req);
			pending = byte_q.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bmpw_pkg::*;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_index = REG_WIDTH;
	logic [DIM_W-1:0] cfg_data  = '0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_stall = 1'b0;
	rsp_t             rsp;
	int unsigned      chk_pending;
	int unsigned      chk_errors;

	stall_mode_t stall_mode = STALL_NONE;
	logic [15:0] stall_tick = '0;

	int unsigned      burst_left = 0;
	int unsigned      sent_cnt   = 0;
	logic [DIM_W-1:0] width_set  = WIDTH_RESET;
	logic [DIM_W-1:0] height_set = HEIGHT_RESET;

	bmp_rgb565_stream_writer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	bmpw_byte_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.pending   (chk_pending),
		.errors    (chk_errors)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// The output side picks a stall style at random whenever the low byte of stall_tick is zero.
	always @(posedge clk) begin
		stall_tick <= stall_tick + 16'd1;
		if (stall_tick[7:0] == 8'd0)
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:     rsp_stall <= 1'b0;
			STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
			STALL_PERIODIC: rsp_stall <= (stall_tick[2:0] < 3'd3);
			default:        rsp_stall <= ($urandom_range(0, 3) != 0);
		endcase
	end

	task automatic send_req(input action_t act, input logic [15:0] px);
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
			                                          : $urandom_range(1, 12);
		end
		req_valid <= 1'b1;
		req       <= '{action: act, pixel_rgb565: px};
		@(posedge clk);
		while (req_stall) @(posedge clk);
		burst_left--;
		sent_cnt++;
	endtask

	task automatic send_pixel();
		send_req(ACT_PIXEL, 16'($urandom_range(0, 65535)));
	endtask

	// Holds off new requests until every predicted byte has come out.
	task automatic settle();
		req_valid <= 1'b0;
		@(negedge clk);
		while (chk_pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_sizes(input bit do_w, input bit do_h,
	                         input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		if (do_w) begin
			write_reg(REG_WIDTH, w);
			width_set = w;
		end
		if (do_h) begin
			write_reg(REG_HEIGHT, h);
			height_set = h;
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DIM_W-1:0] extreme_dim();
		case ($urandom_range(0, 6))
			0:       return 13'd0;
			1:       return 13'd1;
			2:       return 13'd2;
			3:       return 13'd4095;
			4:       return 13'd4096;
			5:       return 13'd4097;
			default: return 13'd8191;
		endcase
	endfunction

	initial begin
		int unsigned pick;
		int unsigned shape;
		int unsigned npx;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A pixel before any start is dropped; then a frame at the reset size.
		send_req(ACT_PIXEL, 16'hFFFF);
		send_req(ACT_START, 16'h0000);
		send_req(ACT_PIXEL, 16'h0000);
		send_req(ACT_PIXEL, 16'hFFFF);
		send_req(ACT_PIXEL, 16'hF800);
		send_req(ACT_PIXEL, 16'h07E0);
		send_req(ACT_PIXEL, 16'h001F);
		send_req(ACT_PIXEL, 16'h0821);
		settle();
		// The new size must not apply to the frame that is still open.
		set_sizes(1'b1, 1'b1, 13'd3, 13'd2);
		send_req(ACT_PIXEL, 16'h5555);
		send_req(ACT_START, 16'hFFFF);
		repeat (6) send_pixel();
		send_req(ACT_PIXEL, 16'hAAAA);
		settle();
		set_sizes(1'b1, 1'b1, 13'd0, 13'd0);
		send_req(ACT_START, 16'h0000);
		send_pixel();
		send_pixel();
		settle();
		set_sizes(1'b1, 1'b1, 13'd8191, 13'd8191);
		send_req(ACT_START, 16'h0000);
		send_pixel();
		settle();
		set_sizes(1'b1, 1'b1, 13'd4096, 13'd4096);
		send_req(ACT_START, 16'h0000);
		send_pixel();

		while (sent_cnt < 370) begin
			settle();
			pick = $urandom_range(0, 15);
			if (pick < 12)
				set_sizes(1'b1, 1'b1, 13'($urandom_range(1, 9)), 13'($urandom_range(1, 4)));
			else if (pick < 14)
				set_sizes(1'b1, 1'b1, extreme_dim(), extreme_dim());
			else if (pick == 14)
				set_sizes(1'b1, 1'b0, 13'($urandom_range(1, 9)), 13'd0);
			else
				set_sizes(1'b0, 1'b1, 13'd0, 13'($urandom_range(1, 4)));

			if (width_set != 0 && height_set != 0 && width_set * height_set <= 64)
				npx = width_set * height_set;
			else
				npx = $urandom_range(1, 12);

			shape = $urandom_range(0, 9);
			if (shape < 6) begin
				send_req(ACT_START, 16'($urandom_range(0, 65535)));
				repeat (npx) send_pixel();
				repeat ($urandom_range(0, 2)) send_pixel();
			end else if (shape < 8) begin
				// Keep feeding whatever frame is open under the earlier size.
				repeat ($urandom_range(1, 8)) send_pixel();
			end else if (shape == 8) begin
				send_req(ACT_START, 16'h0000);
				repeat ($urandom_range(1, npx)) send_pixel();
				send_req(ACT_START, 16'h0000);
				repeat (npx) send_pixel();
			end else begin
				repeat ($urandom_range(1, 10))
					send_req(($urandom_range(0, 5) == 0) ? ACT_START : ACT_PIXEL,
						16'($urandom_range(0, 65535)));
			end
		end

		settle();
		repeat (20) @(posedge clk);
		@(negedge clk);
		if (chk_errors == 0 && chk_pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: bmp_rgb565_stream_writer.f
src/bmpw_pkg.sv
src/bmpw_fifo.sv
src/bmpw_front.sv
src/bmpw_back.sv
src/bmp_rgb565_stream_writer.sv
src/bmpw_checker.sv
tb/bmpw_byte_checker.sv
tb/tb_top.sv
